FILE: rtl/i2a_pkg.sv
`default_nettype none
package i2a_pkg;

  typedef enum logic [1:0] {
    OpSdec = 2'd0,
    OpUdec = 2'd1,
    OpHex  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StScan = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [3:0] DecBase = 4'd10;

  // one digit or nibble to its ascii code
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DecBase) begin
      c = ChZero + {4'd0, d};
    end else begin
      c = ChLowA + {4'd0, d - DecBase};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/i2a_dabble.sv
`default_nettype none
module i2a_dabble #(
  parameter int Digits = 10
) (
  input  logic [Digits*4-1:0] bcd_i,
  input  logic                bit_i,
  output logic [Digits*4-1:0] bcd_o
);

  logic [Digits*4-1:0] adj;

  // add three to every digit of five or more, then shift in the next bit
  always_comb begin
    for (int k = 0; k < Digits; k++) begin
      if (bcd_i[k*4 +: 4] >= 4'd5) begin
        adj[k*4 +: 4] = bcd_i[k*4 +: 4] + 4'd3;
      end else begin
        adj[k*4 +: 4] = bcd_i[k*4 +: 4];
      end
    end
  end

  assign bcd_o = {adj[Digits*4-2:0], bit_i};

endmodule
`default_nettype wire

FILE: rtl/int_to_ascii_digits.sv
// sequence: a decimal word goes through shift-add-3 conversion after it is taken, a hex word
// skips it; then the leading zero digit slots are scanned past before the first character is
// offered, then the characters are offered in turn, each held until the output takes it.
// throughput: one word at a time, ready only when idle, so a new word is not taken until the
// last character of the previous word has been taken.
// reset: rst_ni low clears the sequencer to idle with no output word pending.
`default_nettype none
module int_to_ascii_digits #(
  parameter int WORD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [31:0] value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_code_o,
  output logic       last_char_o
);
  import i2a_pkg::*;

  localparam int DecDigits = (WORD_BITS * 30103) / 100000 + 1;
  localparam int HexDigits = (WORD_BITS + 3) / 4;
  localparam int NDig      = (DecDigits > HexDigits) ? DecDigits : HexDigits;
  localparam int DigW      = $clog2(NDig);
  localparam int CntW      = $clog2(WORD_BITS);
  localparam int BcdW      = NDig * 4;

  state_e             state_q, state_d;
  logic [BcdW-1:0]      bcd_q, bcd_d, bcd_step;
  logic [WORD_BITS-1:0] bin_q, bin_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DigW-1:0]      dig_q, dig_d;
  logic                 sign_q, sign_d;

  logic [WORD_BITS-1:0] w;
  logic                 neg;
  logic [WORD_BITS-1:0] mag;
  logic [3:0]           cur_dig;

  assign w   = WORD_BITS'(value_i);
  assign neg = (opcode_i == OpSdec) && w[WORD_BITS-1];
  assign mag = neg ? WORD_BITS'(~w + 1'b1) : w;

  assign cur_dig = bcd_q[4*dig_q +: 4];

  i2a_dabble #(
    .Digits(NDig)
  ) u_dabble (
    .bcd_i(bcd_q),
    .bit_i(bin_q[WORD_BITS-1]),
    .bcd_o(bcd_step)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign char_code_o = sign_q ? ChMinus : digit_char(cur_dig);
  assign last_char_o = !sign_q && (dig_q == '0);

  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    sign_d  = sign_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          dig_d  = DigW'(NDig - 1);
          sign_d = neg;
          cnt_d  = CntW'(WORD_BITS - 1);
          bin_d  = mag;
          unique case (opcode_i)
            OpSdec, OpUdec: begin
              bcd_d   = '0;
              state_d = StConv;
            end
            OpHex: begin
              bcd_d   = BcdW'(mag);
              state_d = StScan;
            end
            default: begin
              // undefined mode: word dropped, nothing emitted
              state_d = StIdle;
            end
          endcase
        end
      end
      StConv: begin
        bcd_d = bcd_step;
        bin_d = {bin_q[WORD_BITS-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StScan;
        end
      end
      StScan: begin
        // skip leading zero digits, keep at least one
        if (cur_dig == 4'd0 && dig_q != '0) begin
          dig_d = dig_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          if (sign_q) begin
            sign_d = 1'b0;
          end else if (dig_q == '0) begin
            state_d = StIdle;
          end else begin
            dig_d = dig_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sign_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sign_q  <= sign_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
    cnt_q <= cnt_d;
    dig_q <= dig_d;
  end

endmodule
`default_nettype wire

FILE: dv/tb_int_to_ascii_digits.sv
`timescale 1ns / 1ps

module tb_int_to_ascii_digits;
  import i2a_pkg::*;

  localparam int         NumRandom  = 250;
  localparam int         CycleLimit = 400000;
  localparam int         DrainWait  = 100;
  localparam string      DigitSet   = "0123456789abcdef";
  localparam logic [1:0] OpUndef    = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] val;
  } conv_req_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i    = OpSdec;
  logic [31:0] value_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  char_code_o;
  logic        last_char_o;

  conv_req_t   word_queue[$];
  ascii_char_t exp_chars[$];
  conv_req_t   next_req;
  int          errors = 0;
  int          cycles = 0;
  logic        calm;

  int_to_ascii_digits DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stretch with no idling on either side
  assign calm = (cycles >= 2000) && (cycles < 6000);

  // expected text of one word, most significant character first
  function automatic void format_number(input logic [1:0] op, input logic [31:0] word);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [7:0]  digits[$];
    ascii_char_t c;
    mag   = word;
    radix = 32'd10;
    case (op)
      OpHex:  radix = 32'd16;
      OpUdec: radix = 32'd10;
      OpSdec: begin
        if (word[31]) begin
          mag    = ~word + 32'd1;
          c.code = ChMinus;
          c.last = 1'b0;
          exp_chars.push_back(c);
        end
      end
      default: return;
    endcase
    do begin
      digits.push_front(DigitSet[int'(mag % radix)]);
      mag = mag / radix;
    end while (mag != 32'd0);
    foreach (digits[i]) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      exp_chars.push_back(c);
    end
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(99);
      2: return $urandom() >> $urandom_range(31);
      3: return -$urandom_range(1000, 1);
      4: begin
        // around a power of ten
        repeat ($urandom_range(9)) p = p * 32'd10;
        return p + $urandom_range(2) - 32'd1;
      end
      default: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom())};
    endcase
  endfunction

  task automatic add_word(input logic [1:0] op, input logic [31:0] val);
    conv_req_t r;
    r.op  = op;
    r.val = val;
    word_queue.push_back(r);
  endtask

  // driver: holds a word until taken, then predicts it and offers the next
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) format_number(opcode_i, value_i);
      if (word_queue.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
        next_req = word_queue.pop_front();
        in_valid_i <= 1'b1;
        opcode_i   <= next_req.op;
        value_i    <= next_req.val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: checks each taken character against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (exp_chars.size() == 0) begin
          $display("%0t: unexpected char, expected none got %h/%b",
                   $time, char_code_o, last_char_o);
          errors++;
        end else begin
          if (char_code_o !== exp_chars[0].code) begin
            $display("%0t: char_code mismatch, expected %h got %h",
                     $time, exp_chars[0].code, char_code_o);
            errors++;
          end
          if (last_char_o !== exp_chars[0].last) begin
            $display("%0t: last_char mismatch, expected %b got %b",
                     $time, exp_chars[0].last, last_char_o);
            errors++;
          end
          void'(exp_chars.pop_front());
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          n;
    logic [1:0]  op;
    // directed: extremes, every mode, minus sign, most negative word, undefined mode
    add_word(OpSdec, 32'd0);
    add_word(OpUdec, 32'd0);
    add_word(OpHex,  32'd0);
    add_word(OpSdec, 32'd1);
    add_word(OpSdec, 32'd9);
    add_word(OpUdec, 32'd10);
    add_word(OpSdec, 32'hffff_ffff);
    add_word(OpUdec, 32'hffff_ffff);
    add_word(OpHex,  32'hffff_ffff);
    add_word(OpSdec, 32'h8000_0000);
    add_word(OpUdec, 32'h8000_0000);
    add_word(OpHex,  32'h8000_0000);
    add_word(OpSdec, 32'h7fff_ffff);
    add_word(OpHex,  32'hdead_beef);
    add_word(OpHex,  32'h0123_4567);
    add_word(OpHex,  32'h89ab_cdef);
    add_word(OpUdec, 32'd1000000000);
    add_word(OpSdec, 32'hffff_fff6);
    add_word(OpUndef, 32'd12345);
    add_word(OpHex,  32'h0000_000f);
    n = 0;
    while (n < NumRandom) begin
      op = ($urandom_range(99) < 4) ? OpUndef : 2'($urandom_range(2));
      add_word(op, pick_value());
      if (op != OpUndef) n++;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (word_queue.size() > 0 || in_valid_i) @(posedge clk_i);
    while (exp_chars.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (errors == 0 && exp_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
